// File: rtl/shd_pkg.sv
// Shared constants, codes and structs of the signed histogram density core.
package shd_pkg;

   localparam int POS_BINS    = 1024;
   localparam int NEG_BINS    = 1024;
   localparam int COUNT_WIDTH = 32;

   localparam int MAX_BINS = (POS_BINS > NEG_BINS) ? POS_BINS : NEG_BINS;
   localparam int POS_AW   = (POS_BINS > 1) ? $clog2(POS_BINS) : 1;
   localparam int NEG_AW   = (NEG_BINS > 1) ? $clog2(NEG_BINS) : 1;
   // holds a bin count itself, not only an index
   localparam int IDX_W    = $clog2(MAX_BINS + 1);
   localparam int RP_W     = IDX_W + 1;

   // shared divider: dividend wide enough for count * 2^32
   localparam int DVD_W = COUNT_WIDTH + 32;
   localparam int DVS_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam int DCNT_W = $clog2(DVD_W);

   localparam logic [30:0] WIDTH_RESET = 31'd65536;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [1:0] {
      CSR_WIDTH      = 2'd0,
      CSR_LOW_BOUND  = 2'd1,
      CSR_HIGH_BOUND = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        cmd;
      logic        neg;
      logic [31:0] mag;
   } item_type;

   typedef struct packed {
      logic [30:0] step;
      logic [31:0] low_bound;
      logic [31:0] high_bound;
   } cfg_type;

   typedef struct packed {
      logic [10:0] bin_index;
      logic [31:0] bin_center;
      logic [31:0] bin_count;
      logic [31:0] density;
      logic        last;
      logic        empty_res;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

// File: rtl/signed_histogram_density_core.sv
// Top level of the signed histogram density core: registers, front, back.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_command, req_sample
//  rsp      out        rsp_valid / rsp_stall  rsp_bin_index .. rsp_overflow
//  csr      in         csr_write              csr_index, csr_data
//
// After reset a clearing pass zeroes both bin stores; req_stall is high.
// Add beat: one run of the bit-serial divider (64 steps), then the store
// read-modify-write. Read beat: 2 to 4 divider runs; two runs
// when the readout is empty or no sample is counted yet, three when count >= total.
// The two-entry queue takes beats until it is full while the back end works or rsp stalls.
// A stalled result holds in the output register; the back end waits only when the
// next read result is ready and the register is still full.
module signed_histogram_density_core import shd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [31:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [10:0] rsp_bin_index,
   output logic signed [31:0] rsp_bin_center,
   output logic        [31:0] rsp_bin_count,
   output logic        [31:0] rsp_density,
   output logic               rsp_last,
   output logic               rsp_empty_res,
   output logic               rsp_overflow,
   input  logic               csr_write,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_data
);

   logic [30:0]     step_ff, step_in;
   logic [31:0]     low_bound_ff, low_bound_in;
   logic [31:0]     high_bound_ff, high_bound_in;
   cfg_type         cfg;
   logic            item_valid;
   item_type        item;
   back_status_type status;
   rsp_type         rsp;

   always_comb begin
      step_in       = step_ff;
      low_bound_in  = low_bound_ff;
      high_bound_in = high_bound_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:      step_in       = csr_data[30:0];
            CSR_LOW_BOUND:  low_bound_in  = csr_data;
            CSR_HIGH_BOUND: high_bound_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= WIDTH_RESET;
         low_bound_ff  <= '0;
         high_bound_ff <= '0;
      end else begin
         step_ff       <= step_in;
         low_bound_ff  <= low_bound_in;
         high_bound_ff <= high_bound_in;
      end
   end

   assign cfg.step       = step_ff;
   assign cfg.low_bound  = low_bound_ff;
   assign cfg.high_bound = high_bound_ff;

   shd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_sample  (req_sample),
      .item_valid  (item_valid),
      .item        (item),
      .status      (status)
   );

   shd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_bin_index  = rsp.bin_index;
   assign rsp_bin_center = rsp.bin_center;
   assign rsp_bin_count  = rsp.bin_count;
   assign rsp_density    = rsp.density;
   assign rsp_last       = rsp.last;
   assign rsp_empty_res  = rsp.empty_res;
   assign rsp_overflow   = rsp.overflow;

   // no beat may enter while the stores are being cleared
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> req_stall)
      else $error("beat accepted during clearing pass");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> ((rsp_bin_count == 32'd0) && !rsp_last &&
                                         (rsp_density == 32'd0)))
      else $error("empty readout carries bin data");

   a_zero_count_density: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_bin_count == 32'd0)) |-> (rsp_density == 32'd0))
      else $error("density without samples in bin");

   a_neg_center: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_res && rsp_bin_index[10]) |-> rsp_bin_center[31])
      else $error("negative bin with non-negative center");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> item_valid)
      else $error("queue popped while empty");

endmodule

// File: rtl/shd_front.sv
// Front end: accepts beats, splits sample into sign and magnitude, two-entry queue.
module shd_front import shd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_command,
   input  logic [31:0]     req_sample,
   output logic            item_valid,
   output item_type        item,
   input  back_status_type status
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push;
   item_type    new_item;

   assign req_stall  = (fill_ff == 2'd2) || status.clearing;
   assign push       = req_valid && !req_stall;
   assign item_valid = (fill_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.cmd = req_command;
      new_item.neg = req_sample[31];
      // magnitude of the most negative value is 2^31, which fits unsigned
      new_item.mag = req_sample[31] ? (~req_sample + 32'd1) : req_sample;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = status.pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, status.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: rtl/shd_div.sv
// Restoring divider, one quotient bit per cycle.
module shd_div import shd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   logic [DVS_W:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic              take;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      trial   = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      take    = (trial >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? (trial - {1'b0, dvs_ff}) : trial;
         quo_in = {quo_ff[DVD_W-2:0], take};
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == DCNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

// File: rtl/shd_back.sv
// Back end: sequencer over the bin stores, the shared divider and the result register.
module shd_back import shd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            item_valid,
   input  item_type        item,
   output back_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp
);

   localparam int PROD_W = 31 + IDX_W;

   typedef enum logic [17:0] {
      ST_CLEAR    = 18'h00001,
      ST_IDLE     = 18'h00002,
      ST_ADD_DIV  = 18'h00004,
      ST_ADD_WAIT = 18'h00008,
      ST_ADD_RD   = 18'h00010,
      ST_ADD_WR   = 18'h00020,
      ST_NDIV     = 18'h00040,
      ST_NWAIT    = 18'h00080,
      ST_PDIV     = 18'h00100,
      ST_PWAIT    = 18'h00200,
      ST_POS      = 18'h00400,
      ST_MEM      = 18'h00800,
      ST_CNT      = 18'h01000,
      ST_DDIV     = 18'h02000,
      ST_DWAIT    = 18'h04000,
      ST_WDIV     = 18'h08000,
      ST_WWAIT    = 18'h10000,
      ST_OUT      = 18'h20000
   } state_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
   endfunction

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [IDX_W-1:0]       hp_ff, hp_in;
   logic                   pos_used_ff, pos_used_in;
   logic [IDX_W-1:0]       hn_ff, hn_in;
   logic                   clamp_ff, clamp_in;
   logic [RP_W-1:0]        rpos_ff, rpos_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   item_type               item_ff, item_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   bank_neg_ff, bank_neg_in;
   logic                   clamp_pend_ff, clamp_pend_in;
   logic [IDX_W-1:0]       nneg_ff, nneg_in;
   logic [RP_W-1:0]        tlen_ff, tlen_in;
   logic [RP_W-1:0]        p_ff, p_in;
   logic                   last_ff, last_in;
   logic                   empty_ff, empty_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [31:0]            center_ff, center_in;
   logic [DVD_W-1:0]       q_ff, q_in;
   logic [31:0]            dens_ff, dens_in;
   rsp_type                rsp_ff, rsp_in;

   logic [COUNT_WIDTH-1:0] pos_mem [POS_BINS];
   logic [COUNT_WIDTH-1:0] neg_mem [NEG_BINS];
   logic [COUNT_WIDTH-1:0] pos_q_ff, neg_q_ff;
   logic                   rd_en, wr_pos, wr_neg;
   logic [IDX_W-1:0]       rd_addr, wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data, sel_q;

   logic                   div_start, div_done;
   logic [DVD_W-1:0]       div_dvd, div_quo;
   logic [DVS_W-1:0]       div_dvs;

   logic [30:0]            eff_w;
   logic [31:0]            min_mag, max_mag;
   logic                   out_free;

   shd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign eff_w    = (cfg.step == 31'd0) ? 31'd1 : cfg.step;
   assign min_mag  = cfg.low_bound[31] ? (~cfg.low_bound + 32'd1) : cfg.low_bound;
   assign max_mag  = cfg.high_bound[31] ? (~cfg.high_bound + 32'd1) : cfg.high_bound;
   assign sel_q    = bank_neg_ff ? neg_q_ff : pos_q_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.pop      = (state_ff == ST_IDLE) && item_valid;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;

   // store ports
   always_comb begin
      rd_en   = (state_ff == ST_ADD_RD) || (state_ff == ST_MEM);
      rd_addr = idx_ff;
      wr_addr = idx_ff;
      wr_data = sat_inc(sel_q);
      wr_pos  = 1'b0;
      wr_neg  = 1'b0;
      if (state_ff == ST_CLEAR) begin
         wr_addr = clr_ff;
         wr_data = '0;
         wr_pos  = (clr_ff < IDX_W'(POS_BINS));
         wr_neg  = (clr_ff < IDX_W'(NEG_BINS));
      end else if (state_ff == ST_ADD_WR) begin
         wr_pos = !bank_neg_ff;
         wr_neg = bank_neg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pos) begin
         pos_mem[wr_addr[POS_AW-1:0]] <= wr_data;
      end
      if (wr_neg) begin
         neg_mem[wr_addr[NEG_AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         pos_q_ff <= pos_mem[rd_addr[POS_AW-1:0]];
         neg_q_ff <= neg_mem[rd_addr[NEG_AW-1:0]];
      end
   end

   // divider operands by step
   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = DVS_W'(eff_w);
      case (state_ff)
         ST_ADD_DIV: begin
            div_start = 1'b1;
            div_dvd   = DVD_W'({item_ff.mag, 1'b0} + 33'(eff_w));
            div_dvs   = DVS_W'({eff_w, 1'b0});
         end
         ST_NDIV: begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(min_mag);
         end
         ST_PDIV: begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(max_mag);
         end
         ST_DDIV: begin
            div_start = 1'b1;
            div_dvd   = {count_ff, 32'd0};
            div_dvs   = DVS_W'(total_ff);
         end
         ST_WDIV: begin
            div_start = 1'b1;
            div_dvd   = q_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic             a_neg;
      logic [IDX_W-1:0] n_v;
      logic [RP_W-1:0]  p_v;
      logic [RP_W-1:0]  mag_v;
      logic             neg_v;
      logic [31:0]      cm;
      logic [10:0]      bi;

      a_neg = 1'b0;
      n_v   = '0;
      p_v   = '0;
      mag_v = '0;
      neg_v = 1'b0;
      cm    = '0;
      bi    = '0;

      state_in      = state_ff;
      clr_in        = clr_ff;
      total_in      = total_ff;
      hp_in         = hp_ff;
      pos_used_in   = pos_used_ff;
      hn_in         = hn_ff;
      clamp_in      = clamp_ff;
      rpos_in       = rpos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      item_in       = item_ff;
      idx_in        = idx_ff;
      bank_neg_in   = bank_neg_ff;
      clamp_pend_in = clamp_pend_ff;
      nneg_in       = nneg_ff;
      tlen_in       = tlen_ff;
      p_in          = p_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      prod_in       = prod_ff;
      count_in      = count_ff;
      center_in     = center_ff;
      q_in          = q_ff;
      dens_in       = dens_ff;
      rsp_in        = rsp_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               state_in = (item.cmd == CMD_ADD) ? ST_ADD_DIV : ST_NDIV;
            end
         end
         ST_ADD_DIV: state_in = ST_ADD_WAIT;
         ST_ADD_WAIT: begin
            if (div_done) begin
               a_neg         = item_ff.neg && (div_quo != '0);
               clamp_pend_in = 1'b0;
               idx_in        = div_quo[IDX_W-1:0];
               bank_neg_in   = a_neg && (NEG_BINS > 1);
               if (a_neg && (NEG_BINS > 1)) begin
                  if (div_quo > DVD_W'(NEG_BINS - 1)) begin
                     idx_in        = IDX_W'(NEG_BINS - 1);
                     clamp_pend_in = 1'b1;
                  end
               end else if (a_neg) begin
                  // no negative store: negatives that round to a nonzero bin fold onto bin zero
                  idx_in        = '0;
                  clamp_pend_in = 1'b1;
               end else if (div_quo > DVD_W'(POS_BINS - 1)) begin
                  idx_in        = IDX_W'(POS_BINS - 1);
                  clamp_pend_in = 1'b1;
               end
               state_in = ST_ADD_RD;
            end
         end
         ST_ADD_RD: state_in = ST_ADD_WR;
         ST_ADD_WR: begin
            if (bank_neg_ff) begin
               if (idx_ff > hn_ff) begin
                  hn_in = idx_ff;
               end
            end else begin
               if (!pos_used_ff || (idx_ff > hp_ff)) begin
                  hp_in = idx_ff;
               end
               pos_used_in = 1'b1;
            end
            total_in = sat_inc(total_ff);
            clamp_in = clamp_ff || clamp_pend_ff;
            state_in = ST_IDLE;
         end
         ST_NDIV: state_in = ST_NWAIT;
         ST_NWAIT: begin
            if (div_done) begin
               n_v = (div_quo > DVD_W'(NEG_BINS)) ? IDX_W'(NEG_BINS) : div_quo[IDX_W-1:0];
               if ((hn_ff != '0) && ((hn_ff + IDX_W'(1)) > n_v)) begin
                  n_v = hn_ff + IDX_W'(1);
               end
               nneg_in  = (n_v != '0) ? (n_v - IDX_W'(1)) : '0;
               state_in = ST_PDIV;
            end
         end
         ST_PDIV: state_in = ST_PWAIT;
         ST_PWAIT: begin
            if (div_done) begin
               n_v = (div_quo > DVD_W'(POS_BINS)) ? IDX_W'(POS_BINS) : div_quo[IDX_W-1:0];
               if (pos_used_ff && ((hp_ff + IDX_W'(1)) > n_v)) begin
                  n_v = hp_ff + IDX_W'(1);
               end
               tlen_in  = RP_W'(nneg_ff) + RP_W'(n_v);
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            if (tlen_ff == '0) begin
               empty_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               empty_in = 1'b0;
               // a stale position after a register change restarts the readout
               p_v   = (rpos_ff < tlen_ff) ? rpos_ff : '0;
               neg_v = (p_v < RP_W'(nneg_ff));
               mag_v = neg_v ? (RP_W'(nneg_ff) - p_v) : (p_v - RP_W'(nneg_ff));
               p_in        = p_v;
               bank_neg_in = neg_v;
               idx_in      = mag_v[IDX_W-1:0];
               last_in     = (p_v == (tlen_ff - RP_W'(1)));
               state_in    = ST_MEM;
            end
         end
         ST_MEM: begin
            prod_in  = PROD_W'(eff_w) * PROD_W'(idx_ff);
            state_in = ST_CNT;
         end
         ST_CNT: begin
            count_in = sel_q;
            if (bank_neg_ff) begin
               cm = (prod_ff > PROD_W'(33'h080000000)) ? 32'h80000000 : prod_ff[31:0];
               center_in = ~cm + 32'd1;
            end else begin
               center_in = (prod_ff > PROD_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : prod_ff[31:0];
            end
            if (total_ff == '0) begin
               dens_in  = '0;
               state_in = ST_OUT;
            end else if (sel_q >= total_ff) begin
               q_in     = DVD_W'(33'h100000000);
               state_in = ST_WDIV;
            end else begin
               state_in = ST_DDIV;
            end
         end
         ST_DDIV: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_done) begin
               q_in     = div_quo;
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: state_in = ST_WWAIT;
         ST_WWAIT: begin
            if (div_done) begin
               dens_in  = (div_quo > DVD_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : div_quo[31:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.overflow  = clamp_ff;
               rsp_in.empty_res = empty_ff;
               if (empty_ff) begin
                  rsp_in.bin_index  = '0;
                  rsp_in.bin_center = '0;
                  rsp_in.bin_count  = '0;
                  rsp_in.density    = '0;
                  rsp_in.last       = 1'b0;
                  rpos_in           = '0;
               end else begin
                  bi = 11'(idx_ff);
                  rsp_in.bin_index  = bank_neg_ff ? (~bi + 11'd1) : bi;
                  rsp_in.bin_center = center_ff;
                  rsp_in.bin_count  = (count_ff > COUNT_WIDTH'(32'hFFFFFFFF)) ?
                                      32'hFFFFFFFF : 32'(count_ff);
                  rsp_in.density    = dens_ff;
                  rsp_in.last       = last_ff;
                  rpos_in           = last_ff ? '0 : (p_ff + RP_W'(1));
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         hp_ff        <= '0;
         pos_used_ff  <= 1'b0;
         hn_ff        <= '0;
         clamp_ff     <= 1'b0;
         rpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         hp_ff        <= hp_in;
         pos_used_ff  <= pos_used_in;
         hn_ff        <= hn_in;
         clamp_ff     <= clamp_in;
         rpos_ff      <= rpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      bank_neg_ff   <= bank_neg_in;
      clamp_pend_ff <= clamp_pend_in;
      nneg_ff       <= nneg_in;
      tlen_ff       <= tlen_in;
      p_ff          <= p_in;
      last_ff       <= last_in;
      empty_ff      <= empty_in;
      prod_ff       <= prod_in;
      count_ff      <= count_in;
      center_ff     <= center_in;
      q_ff          <= q_in;
      dens_ff       <= dens_in;
      rsp_ff        <= rsp_in;
   end

endmodule
